### hw/rtl/pixel_color_adjust_defines.svh
// Assertion macros shared by the pixel color adjust checker.
`ifndef PIXEL_COLOR_ADJUST_DEFINES_SVH
`define PIXEL_COLOR_ADJUST_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PCA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Property that must hold on the edge after one that sees reset asserted.
`define PCA_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk_i) (!rst_ni) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/pca_pkg.sv
// Shared types, widths and codes of the pixel color adjust block.
package pca_pkg;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned NumChan  = 4;
  localparam int unsigned NumColor = 3;
  localparam int unsigned TabAw    = 8;
  localparam int unsigned TabDw    = 9;
  localparam int unsigned AmtW     = 9;
  localparam int unsigned GainW    = 18;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 18;
  localparam int unsigned SDataW   = 56;
  localparam int unsigned MDataW   = 32;

  localparam logic [ChanW-1:0] GrayCoefR = 8'd54;
  localparam logic [ChanW-1:0] GrayCoefG = 8'd183;
  localparam logic [ChanW-1:0] GrayCoefB = 8'd18;
  localparam logic [AmtW-1:0]  AmtFull   = 9'd256;
  localparam logic [ChanW-1:0] ChanMax   = 8'd255;

  typedef enum logic [1:0] {
    MODE_INVERT = 2'd0,
    MODE_DESAT  = 2'd1,
    MODE_LEVELS = 2'd2,
    MODE_BYPASS = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE      = 3'd0,
    CFG_INV_MASK  = 3'd1,
    CFG_DESAT_AMT = 3'd2,
    CFG_IN_BLACK  = 3'd3,
    CFG_IN_GAIN   = 3'd4,
    CFG_OUT_BLACK = 3'd5,
    CFG_OUT_WHITE = 3'd6
  } cfg_idx_e;

  typedef logic [ChanW-1:0] chan_t;

  typedef struct packed {
    logic             we;
    logic [TabAw-1:0] addr;
    logic [TabDw-1:0] data;
  } gamma_wr_t;

endpackage

### hw/rtl/pca_gamma_ram.sv
// One copy of the gamma table: one write port and one registered read port.
module pca_gamma_ram (
  input  logic                           clk_i,
  input  pca_pkg::gamma_wr_t             wr_i,
  input  logic                           rd_en_i,
  input  logic [pca_pkg::TabAw-1:0]      rd_addr_i,
  output logic [pca_pkg::TabDw-1:0]      rd_data_o
);

  logic [pca_pkg::TabDw-1:0] mem_q [2**pca_pkg::TabAw];
  logic [pca_pkg::TabDw-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### hw/rtl/pixel_color_adjust.sv
// Top level of the pixel color adjust block: a five-stage pixel pipeline.
//
//   Channel   Dir  Handshake                      Payload
//   s_axis    in   s_axis_tvalid / s_axis_tready  tdata: pixel and table fields, tuser: cmd
//   m_axis    out  m_axis_tvalid / m_axis_tready  tdata: adjusted BGRA pixel
//   cfg       in   cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// One word is accepted every cycle while the stages advance; a pixel passes through
// stages 1 to 4 to the output register; a table write produces no output word.
// The gamma table is held in three copies, one per color, so all three lookups of a
// pixel happen in the same cycle.
// All stages advance together whenever the output register is empty or being taken.
// Reset clears the valid bits and loads the default configuration; the table is
// undefined until written.
module pixel_color_adjust (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // Fields from bit 0: in_blue, in_green, in_red, in_alpha, table_index, table_value.
  input  logic [pca_pkg::SDataW-1:0]     s_axis_tdata,
  // Fields from bit 0: cmd.
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // Fields from bit 0: out_blue, out_green, out_red, out_alpha.
  output logic [pca_pkg::MDataW-1:0]     m_axis_tdata,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pca_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [pca_pkg::CfgDataW-1:0]   cfg_data_i
);

  // Configuration registers.
  pca_pkg::mode_e                mode_q;
  logic [3:0]                    inv_mask_q;
  logic [pca_pkg::AmtW-1:0]      desat_amt_q;
  pca_pkg::chan_t                in_black_q;
  logic [pca_pkg::GainW-1:0]     in_gain_q;
  pca_pkg::chan_t                out_black_q;
  pca_pkg::chan_t                out_white_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= pca_pkg::MODE_INVERT;
      inv_mask_q  <= 4'd7;
      desat_amt_q <= pca_pkg::AmtFull;
      in_black_q  <= '0;
      in_gain_q   <= 18'd256;
      out_black_q <= '0;
      out_white_q <= pca_pkg::ChanMax;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pca_pkg::CFG_MODE:      mode_q      <= pca_pkg::mode_e'(cfg_data_i[1:0]);
        pca_pkg::CFG_INV_MASK:  inv_mask_q  <= cfg_data_i[3:0];
        pca_pkg::CFG_DESAT_AMT: desat_amt_q <= cfg_data_i[pca_pkg::AmtW-1:0];
        pca_pkg::CFG_IN_BLACK:  in_black_q  <= cfg_data_i[pca_pkg::ChanW-1:0];
        pca_pkg::CFG_IN_GAIN:   in_gain_q   <= cfg_data_i[pca_pkg::GainW-1:0];
        pca_pkg::CFG_OUT_BLACK: out_black_q <= cfg_data_i[pca_pkg::ChanW-1:0];
        pca_pkg::CFG_OUT_WHITE: out_white_q <= cfg_data_i[pca_pkg::ChanW-1:0];
        default: ;
      endcase
    end
  end

  // Derived configuration values.
  logic [pca_pkg::AmtW-1:0] amt;
  logic [pca_pkg::AmtW-1:0] amt_inv;
  logic signed [8:0]        out_span;

  assign amt      = (desat_amt_q > pca_pkg::AmtFull) ? pca_pkg::AmtFull : desat_amt_q;
  assign amt_inv  = pca_pkg::AmtFull - amt;
  assign out_span = $signed({1'b0, out_white_q}) - $signed({1'b0, out_black_q});

  // Pipeline enable.
  logic out_valid_q;
  logic en;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // Valid and command bits of each stage.
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  logic s1_cmd_q, s2_cmd_q, s3_cmd_q, s4_cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= s_axis_tvalid;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      out_valid_q <= s4_valid_q && !s4_cmd_q;
    end
  end

  // Stage 1: input register.
  pca_pkg::chan_t            s1_ch_q [pca_pkg::NumChan];
  logic [pca_pkg::TabAw-1:0] s1_idx_q;
  logic [pca_pkg::TabDw-1:0] s1_val_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_cmd_q   <= s_axis_tuser;
      s1_ch_q[0] <= s_axis_tdata[7:0];
      s1_ch_q[1] <= s_axis_tdata[15:8];
      s1_ch_q[2] <= s_axis_tdata[23:16];
      s1_ch_q[3] <= s_axis_tdata[31:24];
      s1_idx_q   <= s_axis_tdata[39:32];
      s1_val_q   <= s_axis_tdata[48:40];
    end
  end

  // Stage 2: input gain products and the gray sum.
  pca_pkg::chan_t            s2_ch_q [pca_pkg::NumChan];
  logic [25:0]               s2_lprod_q [pca_pkg::NumColor];
  logic [15:0]               s2_gsum_q;
  logic [pca_pkg::TabAw-1:0] s2_idx_q;
  logic [pca_pkg::TabDw-1:0] s2_val_q;
  logic [25:0]               s2_lprod_d [pca_pkg::NumColor];
  logic [15:0]               s2_gsum_d;

  always_comb begin
    pca_pkg::chan_t diff;
    for (int i = 0; i < pca_pkg::NumColor; i++) begin
      diff          = (s1_ch_q[i] > in_black_q) ? (s1_ch_q[i] - in_black_q) : '0;
      s2_lprod_d[i] = 26'(diff) * 26'(in_gain_q);
    end
    s2_gsum_d = 16'(pca_pkg::GrayCoefR) * 16'(s1_ch_q[2])
              + 16'(pca_pkg::GrayCoefG) * 16'(s1_ch_q[1])
              + 16'(pca_pkg::GrayCoefB) * 16'(s1_ch_q[0]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_cmd_q   <= s1_cmd_q;
      s2_ch_q    <= s1_ch_q;
      s2_lprod_q <= s2_lprod_d;
      s2_gsum_q  <= s2_gsum_d;
      s2_idx_q   <= s1_idx_q;
      s2_val_q   <= s1_val_q;
    end
  end

  // Stage 3: table lookup or table write, and the desaturation mix.
  pca_pkg::chan_t            s3_ch_q [pca_pkg::NumChan];
  logic [16:0]               s3_mix_q [pca_pkg::NumColor];
  logic [16:0]               s3_mix_d [pca_pkg::NumColor];
  logic [pca_pkg::TabAw-1:0] lut_addr [pca_pkg::NumColor];
  logic [pca_pkg::TabDw-1:0] lut_data [pca_pkg::NumColor];
  pca_pkg::gamma_wr_t        lut_wr;
  pca_pkg::chan_t            gray;

  assign gray          = s2_gsum_q[15:8];
  assign lut_wr.we     = en && s2_valid_q && s2_cmd_q;
  assign lut_wr.addr   = s2_idx_q;
  assign lut_wr.data   = s2_val_q;

  always_comb begin
    for (int i = 0; i < pca_pkg::NumColor; i++) begin
      lut_addr[i] = (|s2_lprod_q[i][25:16]) ? pca_pkg::ChanMax : s2_lprod_q[i][15:8];
      s3_mix_d[i] = 17'(s2_ch_q[i]) * 17'(amt_inv) + 17'(gray) * 17'(amt);
    end
  end

  for (genvar g = 0; g < pca_pkg::NumColor; g++) begin : g_lut
    pca_gamma_ram u_ram (
      .clk_i     (clk_i),
      .wr_i      (lut_wr),
      .rd_en_i   (en),
      .rd_addr_i (lut_addr[g]),
      .rd_data_o (lut_data[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_cmd_q <= s2_cmd_q;
      s3_ch_q  <= s2_ch_q;
      s3_mix_q <= s3_mix_d;
    end
  end

  // Stage 4: scale the curve value by the output span.
  pca_pkg::chan_t     s4_ch_q [pca_pkg::NumChan];
  pca_pkg::chan_t     s4_mix_q [pca_pkg::NumColor];
  logic signed [17:0] s4_gprod_q [pca_pkg::NumColor];
  logic signed [17:0] s4_gprod_d [pca_pkg::NumColor];
  pca_pkg::chan_t     s4_mix_d [pca_pkg::NumColor];

  always_comb begin
    logic signed [18:0] prod;
    for (int i = 0; i < pca_pkg::NumColor; i++) begin
      prod          = 19'($signed({1'b0, lut_data[i]})) * 19'(out_span);
      s4_gprod_d[i] = 18'(prod);
      s4_mix_d[i]   = s3_mix_q[i][15:8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_cmd_q   <= s3_cmd_q;
      s4_ch_q    <= s3_ch_q;
      s4_mix_q   <= s4_mix_d;
      s4_gprod_q <= s4_gprod_d;
    end
  end

  // Stage 5: offset and clamp, then select by mode into the output register.
  pca_pkg::chan_t out_ch_d [pca_pkg::NumChan];
  pca_pkg::chan_t lvl_ch [pca_pkg::NumColor];
  logic [pca_pkg::MDataW-1:0] out_data_q;

  always_comb begin
    logic signed [9:0]  scaled;
    logic signed [10:0] res;
    for (int i = 0; i < pca_pkg::NumColor; i++) begin
      scaled = 10'(s4_gprod_q[i] >>> 8);
      res    = $signed({3'b000, out_black_q}) + 11'(scaled);
      if (res < 11'sd0) begin
        lvl_ch[i] = '0;
      end else if (res > 11'sd255) begin
        lvl_ch[i] = pca_pkg::ChanMax;
      end else begin
        lvl_ch[i] = res[7:0];
      end
    end
  end

  always_comb begin
    out_ch_d = s4_ch_q;
    case (mode_q)
      pca_pkg::MODE_INVERT: begin
        for (int i = 0; i < pca_pkg::NumChan; i++) begin
          out_ch_d[i] = inv_mask_q[i] ? ~s4_ch_q[i] : s4_ch_q[i];
        end
      end
      pca_pkg::MODE_DESAT: begin
        for (int i = 0; i < pca_pkg::NumColor; i++) begin
          out_ch_d[i] = s4_mix_q[i];
        end
      end
      pca_pkg::MODE_LEVELS: begin
        for (int i = 0; i < pca_pkg::NumColor; i++) begin
          out_ch_d[i] = lvl_ch[i];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= {out_ch_d[3], out_ch_d[2], out_ch_d[1], out_ch_d[0]};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

### hw/rtl/pca_checker.sv
// Port-level checker of the pixel color adjust block, bound to its top level.
`include "pixel_color_adjust_defines.svh"

module pca_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic                       s_axis_tuser,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [pca_pkg::MDataW-1:0] m_axis_tdata
);

  `PCA_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output word changed while stalled")
  `PCA_ASSERT_IMP(a_ready_tracks_out, 1'b1, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "input ready does not follow output stall")
  `PCA_ASSERT_NXT(a_pixel_latency, s_axis_tvalid && s_axis_tready && !s_axis_tuser ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready, m_axis_tvalid, "pixel did not reach the output in four cycles")
  `PCA_ASSERT_RST(a_reset_empty, !m_axis_tvalid, "output valid after reset")

endmodule

bind pixel_color_adjust pca_checker u_pca_checker (.*);
